FILE: design/assert_macros.svh
// assertion macros used by the top-level design file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication in the same cycle, disabled during reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// implication in the next cycle, checked during reset too
`define ASSERT_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: design/jsu_pkg.sv
// types, codes and helper functions for the json string unescaper
// no dependencies
package jsu_pkg;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_CLOSE = 2'd1;
    localparam logic [1:0] KIND_ERROR = 2'd2;

    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_NO_QUOTE  = 3'd1;
    localparam logic [2:0] ERR_END_BODY  = 3'd2;
    localparam logic [2:0] ERR_END_ESC   = 3'd3;
    localparam logic [2:0] ERR_END_HEX   = 3'd4;
    localparam logic [2:0] ERR_BAD_HEX   = 3'd5;
    localparam logic [2:0] ERR_BAD_ESC   = 3'd6;
    localparam logic [2:0] ERR_CTRL_CHAR = 3'd7;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5c;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_U      = 8'h75;

    typedef enum logic [3:0] {
        MODE_WAIT = 4'b0001,
        MODE_BODY = 4'b0010,
        MODE_ESC  = 4'b0100,
        MODE_HEX  = 4'b1000
    } t_mode;

    // one queued command: up to three result bytes from one input item
    typedef struct packed {
        logic [1:0]      kind;
        logic [2:0]      err_code;
        logic [2:0][7:0] bytes;
        logic [1:0]      nbeats;
    } t_cmd;

    typedef struct packed {
        logic       ok;
        logic [7:0] value;
    } t_esc;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } t_hex;

    function automatic t_esc esc_decode(input logic [7:0] c);
        t_esc r;
        r.ok = 1'b1;
        r.value = c;
        unique case (c)
            8'h22, 8'h5c, 8'h2f: r.value = c;
            8'h62: r.value = 8'h08;
            8'h66: r.value = 8'h0c;
            8'h6e: r.value = 8'h0a;
            8'h72: r.value = 8'h0d;
            8'h74: r.value = 8'h09;
            default: begin
                r.ok = 1'b0;
                r.value = 8'h00;
            end
        endcase
        return r;
    endfunction

    function automatic t_hex hex_decode(input logic [7:0] c);
        t_hex r;
        r.ok = 1'b1;
        r.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r.value = 4'(c - 8'h30);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r.value = 4'(c - 8'h41 + 8'd10);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r.value = 4'(c - 8'h61 + 8'd10);
        end else begin
            r.ok = 1'b0;
        end
        return r;
    endfunction

    function automatic t_cmd utf8_encode(input logic [15:0] code);
        t_cmd r;
        r.kind = KIND_BYTE;
        r.err_code = ERR_NONE;
        r.bytes = '0;
        if (code[15:7] == 9'd0) begin
            r.bytes[0] = code[7:0];
            r.nbeats = 2'd1;
        end else if (code[15:11] == 5'd0) begin
            r.bytes[0] = 8'hc0 | {3'b000, code[10:6]};
            r.bytes[1] = 8'h80 | {2'b00, code[5:0]};
            r.nbeats = 2'd2;
        end else begin
            r.bytes[0] = 8'he0 | {4'b0000, code[15:12]};
            r.bytes[1] = 8'h80 | {2'b00, code[11:6]};
            r.bytes[2] = 8'h80 | {2'b00, code[5:0]};
            r.nbeats = 2'd3;
        end
        return r;
    endfunction

endpackage

FILE: design/jsu_front.sv
// front end: string state machine, classifies each item and yields a command for some of them
// depends on jsu_pkg
module jsu_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_in_byte,
    input  logic          i_end_of_input,
    output logic          o_push,
    output jsu_pkg::t_cmd o_cmd
);
    import jsu_pkg::*;

    t_mode       r_mode, n_mode;
    logic [1:0]  r_hex_count, n_hex_count;
    logic [15:0] r_code_accum, n_code_accum;
    logic        produce;
    t_esc        esc;
    t_hex        hex;
    logic [15:0] code;

    assign esc  = esc_decode(i_in_byte);
    assign hex  = hex_decode(i_in_byte);
    assign code = {r_code_accum[11:0], hex.value};

    always_comb begin
        n_mode       = r_mode;
        n_hex_count  = r_hex_count;
        n_code_accum = r_code_accum;
        produce      = 1'b0;
        o_cmd        = '0;
        o_cmd.kind   = KIND_BYTE;
        o_cmd.nbeats = 2'd1;
        unique case (r_mode)
            MODE_WAIT: begin
                if (i_end_of_input || i_in_byte != CH_QUOTE) begin
                    produce = 1'b1;
                    o_cmd.kind = KIND_ERROR;
                    o_cmd.err_code = ERR_NO_QUOTE;
                end else begin
                    n_mode = MODE_BODY;
                end
            end
            MODE_BODY: begin
                if (i_end_of_input) begin
                    produce = 1'b1;
                    o_cmd.kind = KIND_ERROR;
                    o_cmd.err_code = ERR_END_BODY;
                end else if (i_in_byte == CH_QUOTE) begin
                    produce = 1'b1;
                    o_cmd.kind = KIND_CLOSE;
                    n_mode = MODE_WAIT;
                end else if (i_in_byte == CH_BSLASH) begin
                    n_mode = MODE_ESC;
                end else if (i_in_byte < CH_SPACE) begin
                    produce = 1'b1;
                    o_cmd.kind = KIND_ERROR;
                    o_cmd.err_code = ERR_CTRL_CHAR;
                end else begin
                    produce = 1'b1;
                    o_cmd.bytes[0] = i_in_byte;
                end
            end
            MODE_ESC: begin
                if (i_end_of_input) begin
                    produce = 1'b1;
                    o_cmd.kind = KIND_ERROR;
                    o_cmd.err_code = ERR_END_ESC;
                end else if (i_in_byte == CH_U) begin
                    n_mode = MODE_HEX;
                    n_hex_count = 2'd0;
                    n_code_accum = 16'd0;
                end else if (esc.ok) begin
                    produce = 1'b1;
                    o_cmd.bytes[0] = esc.value;
                    n_mode = MODE_BODY;
                end else begin
                    produce = 1'b1;
                    o_cmd.kind = KIND_ERROR;
                    o_cmd.err_code = ERR_BAD_ESC;
                end
            end
            MODE_HEX: begin
                if (i_end_of_input) begin
                    produce = 1'b1;
                    o_cmd.kind = KIND_ERROR;
                    o_cmd.err_code = ERR_END_HEX;
                end else if (!hex.ok) begin
                    produce = 1'b1;
                    o_cmd.kind = KIND_ERROR;
                    o_cmd.err_code = ERR_BAD_HEX;
                end else if (r_hex_count == 2'd3) begin
                    produce = 1'b1;
                    o_cmd = utf8_encode(code);
                    n_mode = MODE_BODY;
                    n_hex_count = 2'd0;
                    n_code_accum = 16'd0;
                end else begin
                    n_code_accum = code;
                    n_hex_count = r_hex_count + 2'd1;
                end
            end
            default: begin
                n_mode = MODE_WAIT;
            end
        endcase
        // any error returns to the idle state
        if (o_cmd.kind == KIND_ERROR) begin
            n_mode = MODE_WAIT;
            n_hex_count = 2'd0;
            n_code_accum = 16'd0;
        end
    end

    assign o_push = i_accept && produce;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode       <= MODE_WAIT;
            r_hex_count  <= 2'd0;
            r_code_accum <= 16'd0;
        end else if (i_accept) begin
            r_mode       <= n_mode;
            r_hex_count  <= n_hex_count;
            r_code_accum <= n_code_accum;
        end
    end

endmodule

FILE: design/jsu_queue.sv
// small command queue between front and back end
// depends on jsu_pkg
module jsu_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  jsu_pkg::t_cmd i_cmd,
    output logic          o_not_full,
    input  logic          i_pop,
    output logic          o_not_empty,
    output jsu_pkg::t_cmd o_cmd
);
    import jsu_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);

    t_cmd          r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_not_full  = r_count != CW'(DEPTH);
    assign o_not_empty = r_count != '0;
    assign o_cmd       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: design/jsu_back.sv
// back end: splits each command into result items, output register
// depends on jsu_pkg
module jsu_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_cmd_valid,
    input  jsu_pkg::t_cmd i_cmd,
    output logic          o_pop,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [1:0]    o_kind,
    output logic [2:0]    o_error_code,
    output logic [7:0]    o_out_byte,
    output logic          o_last
);
    import jsu_pkg::*;

    logic       r_valid;
    logic [1:0] r_kind;
    logic [2:0] r_err;
    logic [7:0] r_byte;
    logic       r_last;
    logic [1:0] r_beat;
    logic       load;
    logic       beat_last;

    assign load      = i_cmd_valid && (!r_valid || i_ready);
    assign beat_last = r_beat == (i_cmd.nbeats - 2'd1);
    assign o_pop     = load && beat_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_beat  <= 2'd0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_beat  <= beat_last ? 2'd0 : r_beat + 2'd1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_kind <= i_cmd.kind;
            r_err  <= i_cmd.err_code;
            r_byte <= i_cmd.bytes[r_beat];
            r_last <= beat_last;
        end
    end

    assign o_valid      = r_valid;
    assign o_kind       = r_kind;
    assign o_error_code = r_err;
    assign o_out_byte   = r_byte;
    assign o_last       = r_last;

endmodule

FILE: design/json_string_unescape.sv
// top level of the json string unescaper
// depends on jsu_pkg, jsu_front, jsu_queue, jsu_back and assert_macros.svh
//
// input channel: i_valid / o_ready with i_in_byte and i_end_of_input, one
// raw byte or an end mark per item. output channel: o_valid / i_ready with
// o_kind, o_error_code, o_out_byte and o_last, one result per item.
// the front end takes one input item per cycle while the command queue has
// room; o_valid for the first result of an item rises once its command has
// passed through the queue memory into the back end's output register.
// the back end sends one result per cycle while the receiver is ready, and a
// \u escape yields one, two or three utf-8 bytes, each a separate result
// at the output port. o_last marks the last result from a given input item.
// a stalled receiver holds the output register; the queue then fills and
// o_ready drops once QUEUE_DEPTH commands wait.
// synchronous reset empties the queue and output, and returns the parser to
// waiting for an opening quote.
`include "assert_macros.svh"

module json_string_unescape #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_input,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [1:0] o_kind,
    output logic [2:0] o_error_code,
    output logic [7:0] o_out_byte,
    output logic       o_last
);
    import jsu_pkg::*;

    logic accept;
    logic push;
    logic pop;
    logic q_not_full;
    logic q_not_empty;
    t_cmd f_cmd;
    t_cmd q_cmd;

    assign o_ready = q_not_full;
    assign accept  = i_valid && q_not_full;

    jsu_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_in_byte      (i_in_byte),
        .i_end_of_input (i_end_of_input),
        .o_push         (push),
        .o_cmd          (f_cmd)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_cmd       (f_cmd),
        .o_not_full  (q_not_full),
        .i_pop       (pop),
        .o_not_empty (q_not_empty),
        .o_cmd       (q_cmd)
    );

    jsu_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd_valid  (q_not_empty),
        .i_cmd        (q_cmd),
        .o_pop        (pop),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_kind       (o_kind),
        .o_error_code (o_error_code),
        .o_out_byte   (o_out_byte),
        .o_last       (o_last)
    );

    `ASSERT_NEXT(a_reset_clears_out, i_clk, !i_rst_n, !o_valid)
    `ASSERT_IMPL(a_err_only_on_error, i_clk, i_rst_n,
        o_valid && o_kind != KIND_ERROR, o_error_code == ERR_NONE)
    `ASSERT_IMPL(a_single_beat_last, i_clk, i_rst_n,
        o_valid && o_kind != KIND_BYTE, o_last && o_out_byte == 8'h00)
    `ASSERT_IMPL(a_error_coded, i_clk, i_rst_n,
        o_valid && o_kind == KIND_ERROR, o_error_code != ERR_NONE)

endmodule
